// ----- rtl/core/picr_pkg.sv -----
// Shared types, register indexes and saturation helper for the PI current regulator.
package picr_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_WINDUP_GAIN = 3'd2,
    REG_OUT_UPPER   = 3'd3,
    REG_OUT_LOWER   = 3'd4,
    REG_INTEG_ON    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [30:0] prop_gain;
    logic        [30:0] integ_gain;
    logic signed [31:0] windup_gain;
    logic signed [31:0] out_upper;
    logic signed [31:0] out_lower;
    logic               integ_on;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_prop;
    logic take_prop;
    logic take_windup;
    logic update_integ;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [41:0] hi;
    logic signed [41:0] lo;
    hi = 42'sh0_7FFF_FFFF;
    lo = -42'sh0_8000_0000;
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return -32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ----- rtl/core/picr_if.sv -----
// Handshake channel interfaces for regulator samples and results.
interface picr_sample_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] reference;
  logic signed [31:0] feedback;

  modport source (output valid, output mode, output reference, output feedback, input ready);
  modport sink (input valid, input mode, input reference, input feedback, output ready);
endinterface

interface picr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink (input valid, input drive, input clamped, output ready);
endinterface

// ----- rtl/core/picr_ctrl.sv -----
// Sequencer for one regulator step: multiply, accumulate, limit, deliver; a reset item skips to deliver.
module picr_ctrl import picr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_mode,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MPROP = 6'b000010,
    ST_SATP  = 6'b000100,
    ST_MINT  = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = in_mode ? ST_FIN : ST_MPROP;
        end
      end
      ST_MPROP: state_next = ST_SATP;
      ST_SATP:  state_next = ST_MINT;
      ST_MINT:  state_next = ST_ACC;
      ST_ACC:   state_next = ST_FIN;
      ST_FIN: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd              = '0;
    cmd.load         = accept;
    cmd.mul_prop     = (state == ST_MPROP);
    cmd.take_prop    = (state == ST_SATP);
    cmd.take_windup  = (state == ST_MINT);
    cmd.update_integ = (state == ST_ACC);
    cmd.finish       = (state == ST_FIN) && stat.out_free;
  end

endmodule

// ----- rtl/core/picr_datapath.sv -----
// Regulator datapath: shared multiplier, integrator, output limiter and result register.
module picr_datapath import picr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_mode,
  input  logic signed [31:0] in_reference,
  input  logic signed [31:0] in_feedback,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] out_drive,
  output logic               out_clamped
);

  logic               mode_r;
  logic signed [32:0] err;
  logic signed [63:0] prod;
  logic signed [31:0] prop;
  logic signed [39:0] wterm;
  logic signed [31:0] integ_acc;
  logic signed [31:0] prev_prop;
  logic signed [31:0] sat_diff;
  logic               clamp_pass;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;
  logic signed [39:0] prod_q;
  logic signed [41:0] integ_sum;
  logic signed [31:0] integ_new;
  logic signed [32:0] presat;
  logic signed [32:0] upper_x;
  logic signed [32:0] lower_x;
  logic signed [32:0] drive_x;
  logic               pass;
  logic signed [33:0] diff;

  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    priority if (cmd.take_prop) begin
      mul_a = 33'(cfg.windup_gain);
      mul_b = 33'(sat_diff);
    end else if (cmd.take_windup) begin
      mul_a = $signed({2'b00, cfg.integ_gain});
      mul_b = 33'(prop) + 33'(prev_prop);
    end else begin
      mul_a = $signed({2'b00, cfg.prop_gain});
      mul_b = err;
    end
  end

  assign mul_full = mul_a * mul_b;
  assign prod_q   = 40'(prod >>> 24);

  always_comb begin
    if (cfg.windup_gain < 0) begin
      integ_sum = 42'(integ_acc) + 42'(prod_q);
      integ_new = clamp_pass ? sat32(integ_sum) : '0;
    end else begin
      integ_sum = 42'(integ_acc) + 42'(prod_q) + 42'(wterm);
      integ_new = sat32(integ_sum);
    end
  end

  always_comb begin
    presat  = 33'(prop) + 33'(integ_acc);
    upper_x = 33'(cfg.out_upper);
    lower_x = 33'(cfg.out_lower);
    priority if (presat > upper_x) begin
      drive_x = upper_x;
      pass    = 1'b0;
    end else if (presat < lower_x) begin
      drive_x = lower_x;
      pass    = 1'b0;
    end else begin
      drive_x = presat;
      pass    = 1'b1;
    end
    diff = 34'(drive_x) - 34'(presat);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      err    <= 33'(in_reference) - 33'(in_feedback);
    end
    if (cmd.mul_prop || cmd.take_prop || cmd.take_windup) begin
      prod <= $signed(mul_full[63:0]);
    end
    if (cmd.take_prop) begin
      prop <= sat32(42'(prod_q));
    end
    if (cmd.take_windup) begin
      wterm <= prod_q;
    end
    if (cmd.finish) begin
      out_drive   <= mode_r ? '0 : drive_x[31:0];
      out_clamped <= mode_r ? 1'b0 : !pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc  <= '0;
      prev_prop  <= '0;
      sat_diff   <= '0;
      clamp_pass <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.update_integ) begin
        integ_acc <= cfg.integ_on ? integ_new : '0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (mode_r) begin
          integ_acc  <= '0;
          prev_prop  <= '0;
          sat_diff   <= '0;
          clamp_pass <= 1'b1;
        end else begin
          prev_prop  <= prop;
          sat_diff   <= sat32(42'(diff));
          clamp_pass <= pass;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/pi_current_regulator_antiwindup.sv -----
// Top level of the PI current regulator with anti-windup.
// A control step (mode 0) goes from acceptance to a result in the output register as
// follows: one shared 33x33 multiplier forms the proportional, back-calculation and
// integral products in turn, followed by an accumulate step and a limit step. A reset
// item (mode 1) goes straight to the result write. One item is in work at a time; a new
// sample is accepted the cycle after the previous result is written, while that result
// may still wait on the result channel. The last cycle of an item holds until the result
// register is free. Configuration writes take effect on the next clock edge.
module pi_current_regulator_antiwindup import picr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  picr_sample_if.sink        sample,
  picr_result_if.source      result,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:   cfg.prop_gain   <= cfg_data[30:0];
        REG_INTEG_GAIN:  cfg.integ_gain  <= cfg_data[30:0];
        REG_WINDUP_GAIN: cfg.windup_gain <= $signed(cfg_data);
        REG_OUT_UPPER:   cfg.out_upper   <= $signed(cfg_data);
        REG_OUT_LOWER:   cfg.out_lower   <= $signed(cfg_data);
        REG_INTEG_ON:    cfg.integ_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  picr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_mode  (sample.mode),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  picr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .in_mode      (sample.mode),
    .in_reference (sample.reference),
    .in_feedback  (sample.feedback),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_drive    (result.drive),
    .out_clamped  (result.clamped)
  );

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while a step is in work");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.clamped |->
      (result.drive == cfg.out_upper) || (result.drive == cfg.out_lower))
    else $error("clamped result not at a limit");

  a_pass_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.clamped |->
      ((result.drive <= cfg.out_upper) && (result.drive >= cfg.out_lower)) ||
      (result.drive == 32'sd0))
    else $error("unclamped result outside limits");

endmodule
